### design/button_debounce_press_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce press classifier
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BDPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("bdpc: same-cycle check failed");

// next-cycle implication
`define BDPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("bdpc: next-cycle check failed");

`else

`define BDPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BDPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### design/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types, codes and constants shared by the debounce classifier modules.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int BUTTON_COUNT_DEF = 8;
  localparam int MAX_BUTTONS      = 8;

  localparam int DB_THR_W   = 8;
  localparam int LONG_THR_W = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DB_THR_W-1:0]   DB_THR_RST   = 8'd1;
  localparam logic [LONG_THR_W-1:0] LONG_THR_RST = 16'd10;
  localparam logic [MASK_W-1:0]     EN_MASK_RST  = 8'hFF;

  localparam logic [DB_THR_W-1:0]   DCNT_MAX = 8'hFF;
  localparam logic [LONG_THR_W-1:0] HCNT_MAX = 16'hFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_THR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 2'd2;

  // input commands
  localparam logic CMD_MASK = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_SHORT   = 2'd2,
    ACT_LONG    = 2'd3
  } action_t;

  typedef struct packed {
    logic              command;
    logic [MASK_W-1:0] btn_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0] button_index;
    action_t    action;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [DB_THR_W-1:0]   debounce_thr;
    logic [LONG_THR_W-1:0] long_thr;
  } lane_cfg_t;

  // events one lane raises on a tick: a primary event and a trailing short press
  typedef struct packed {
    logic    first_vld;
    action_t first_act;
    logic    short_vld;
  } lane_ev_t;

endpackage

### design/bdpc_lane.sv
// ----------------------------------------------------------------------------
// bdpc_lane
// Per-button debounce and hold counters; flags the events of one tick.
// ----------------------------------------------------------------------------
module bdpc_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                raw_on,
  input  bdpc_pkg::lane_cfg_t cfg,
  output bdpc_pkg::lane_ev_t  ev
);

  logic [bdpc_pkg::DB_THR_W-1:0]   dcnt_r, dcnt_nxt, dcnt_inc;
  logic [bdpc_pkg::LONG_THR_W-1:0] hcnt_r, hcnt_nxt, hcnt_inc;
  logic                            stable_r, stable_nxt;
  logic                            lrep_r, lrep_nxt;

  always_comb begin
    dcnt_inc   = (dcnt_r == bdpc_pkg::DCNT_MAX) ? dcnt_r : dcnt_r + 8'd1;
    hcnt_inc   = (hcnt_r == bdpc_pkg::HCNT_MAX) ? hcnt_r : hcnt_r + 16'd1;
    dcnt_nxt   = dcnt_r;
    hcnt_nxt   = hcnt_r;
    stable_nxt = stable_r;
    lrep_nxt   = lrep_r;
    ev         = '{first_vld: 1'b0, first_act: bdpc_pkg::ACT_PRESS, short_vld: 1'b0};
    if (raw_on != stable_r) begin
      if (dcnt_inc >= cfg.debounce_thr) begin
        // commit the change
        dcnt_nxt     = '0;
        hcnt_nxt     = '0;
        lrep_nxt     = 1'b0;
        stable_nxt   = raw_on;
        ev.first_vld = 1'b1;
        if (raw_on) begin
          ev.first_act = bdpc_pkg::ACT_PRESS;
        end else begin
          ev.first_act = bdpc_pkg::ACT_RELEASE;
          ev.short_vld = !lrep_r;
        end
      end else begin
        dcnt_nxt = dcnt_inc;
      end
    end else begin
      dcnt_nxt = '0;
      if (stable_r) begin
        hcnt_nxt = hcnt_inc;
        if ((hcnt_inc >= cfg.long_thr) && !lrep_r) begin
          ev.first_vld = 1'b1;
          ev.first_act = bdpc_pkg::ACT_LONG;
          lrep_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r   <= '0;
      hcnt_r   <= '0;
      stable_r <= 1'b0;
      lrep_r   <= 1'b0;
    end else if (step) begin
      dcnt_r   <= dcnt_nxt;
      hcnt_r   <= hcnt_nxt;
      stable_r <= stable_nxt;
      lrep_r   <= lrep_nxt;
    end
  end

endmodule

### design/bdpc_merge.sv
// ----------------------------------------------------------------------------
// bdpc_merge
// Collects lane events of one tick and sends them out in button order.
// ----------------------------------------------------------------------------
module bdpc_merge #(
  parameter int BUTTON_COUNT = bdpc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bdpc_pkg::lane_ev_t  ev [BUTTON_COUNT],
  output logic                idle,
  output logic                out_valid,
  input  logic                out_ready,
  output bdpc_pkg::out_item_t out_data
);

  localparam int PEND_W = 2 * BUTTON_COUNT;
  localparam int SEL_W  = $clog2(PEND_W);
  localparam int BTN_W  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  logic [PEND_W-1:0]   pend_r, load_vec, sel_hot;
  bdpc_pkg::action_t   act_r [BUTTON_COUNT];
  logic [SEL_W-1:0]    sel;
  logic [BTN_W-1:0]    btn_sel;
  logic                have, take;
  logic                out_valid_r;
  bdpc_pkg::out_item_t out_data_r, item;

  always_comb begin
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      load_vec[2*b]   = ev[b].first_vld;
      load_vec[2*b+1] = ev[b].short_vld;
    end
  end

  // lowest pending event wins
  always_comb begin
    sel = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign sel_hot = PEND_W'(1) << sel;
  assign btn_sel = BTN_W'(sel >> 1);
  assign have    = |pend_r;
  assign take    = have && (!out_valid_r || out_ready);

  always_comb begin
    item.button_index = 3'(btn_sel);
    item.action       = sel[0] ? bdpc_pkg::ACT_SHORT : act_r[btn_sel];
    item.last_of_run  = ((pend_r & ~sel_hot) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pend_r <= load_vec;
      end else if (take) begin
        pend_r <= pend_r & ~sel_hot;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= item;
    end
    if (load) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        act_r[b] <= ev[b].first_act;
      end
    end
  end

  assign idle      = !have;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a bank of buttons and reports press, release, short and long.
// ----------------------------------------------------------------------------
// Use:
//   in_*  : valid/ready channel of in_item_t. command CMD_MASK latches a new
//           raw pressed mask (ANDed with the enable mask); CMD_TICK advances
//           time by one tick. Ticks before the first mask are swallowed.
//   out_* : valid/ready channel of out_item_t, events in button order; the
//           final event of a tick carries last_of_run.
//   cfg_* : register write channel, always ready. Write only while idle.
// Flow:
//   All lanes update together on the accepted tick transfer, which loads
//   their events into the merge stage's pending-event vector; the merge
//   stage then moves one event a cycle into the output register while that
//   register is empty or out_ready is high. A tick raising n events (up to
//   2*BUTTON_COUNT) holds in_ready low until the last event has entered the
//   output register. Mask items and silent ticks leave in_ready high.
//   The single output register and pending-event vector set this rate.
// Reset (synchronous, rst_n low): registers return to defaults, all counters
//   and stable state clear, no mask seen, output empty.
// Stall: when out_ready is low the output register holds its event and the
//   pending events wait; the input stays blocked until they have drained.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_macros.svh"

module button_debounce_press_classifier #(
  parameter int BUTTON_COUNT = bdpc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bdpc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bdpc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [bdpc_pkg::DB_THR_W-1:0]   db_thr_r;
  logic [bdpc_pkg::LONG_THR_W-1:0] long_thr_r;
  logic [bdpc_pkg::MASK_W-1:0]     en_mask_r;

  // raw input state
  logic [bdpc_pkg::MASK_W-1:0]     raw_bits_r;
  logic                            raw_seen_r;

  logic                            in_xfer, tick_step, merge_idle;
  logic                            mask_xfer, early_tick;
  bdpc_pkg::lane_cfg_t             lane_cfg;
  bdpc_pkg::lane_ev_t              lane_ev [BUTTON_COUNT];

  assign cfg_ready = 1'b1;
  assign in_ready  = merge_idle;
  assign in_xfer   = in_valid && in_ready;
  // a tick only steps the lanes once a mask has been seen
  assign tick_step = in_xfer && (in_data.command == bdpc_pkg::CMD_TICK) && raw_seen_r;
  assign mask_xfer  = in_xfer && (in_data.command == bdpc_pkg::CMD_MASK);
  assign early_tick = in_xfer && (in_data.command == bdpc_pkg::CMD_TICK) && !raw_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_thr_r   <= bdpc_pkg::DB_THR_RST;
      long_thr_r <= bdpc_pkg::LONG_THR_RST;
      en_mask_r  <= bdpc_pkg::EN_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdpc_pkg::REG_DEBOUNCE_THR: db_thr_r   <= cfg_data[bdpc_pkg::DB_THR_W-1:0];
        bdpc_pkg::REG_LONG_THR:     long_thr_r <= cfg_data;
        bdpc_pkg::REG_ENABLE_MASK:  en_mask_r  <= cfg_data[bdpc_pkg::MASK_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_bits_r <= '0;
      raw_seen_r <= 1'b0;
    end else if (mask_xfer) begin
      raw_bits_r <= in_data.btn_mask & en_mask_r;
      raw_seen_r <= 1'b1;
    end
  end

  assign lane_cfg = '{debounce_thr: db_thr_r, long_thr: long_thr_r};

  // one lane per button, all stepping on the same tick
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    bdpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (tick_step),
      .raw_on (raw_bits_r[b]),
      .cfg    (lane_cfg),
      .ev     (lane_ev[b])
    );
  end

  // serialises the tick's events onto the output channel
  bdpc_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (tick_step),
    .ev        (lane_ev),
    .idle      (merge_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a mask transfer never starts an event run
  `BDPC_ASSERT_NXT(a_mask_silent, clk, rst_n, mask_xfer, in_ready)

  // a tick before any mask leaves the block idle
  `BDPC_ASSERT_NXT(a_early_tick_silent, clk, rst_n, early_tick, in_ready)

  // an event that is not the last of its run means more are pending
  `BDPC_ASSERT_IMP(a_run_blocks_input, clk, rst_n, out_valid && !out_data.last_of_run, !in_ready)

endmodule
